>>> src/cfcr_pkg.sv
// ----------------------------------------------------------------------------
// cfcr_pkg
// Types and constants shared by the CAN frame classifier and reassembler.
// ----------------------------------------------------------------------------
package cfcr_pkg;

  // Identifier and length codes
  localparam logic [10:0] ID_CONTROL    = 11'h000;
  localparam logic [10:0] ID_DATA_FIRST = 11'h100;
  localparam logic [6:0]  ID_PEER_HI    = 7'h60;   // id[10:4] of 0x600..0x60F
  localparam logic [7:0]  ID_FRAG_HI    = 8'h20;   // id[10:3] of 0x100..0x107
  localparam logic [3:0]  DLC_8_BYTES   = 4'd8;
  localparam logic [3:0]  DLC_64_BYTES  = 4'd15;
  localparam logic [3:0]  PEER_LIMIT_RESET = 4'd8;
  localparam logic [2:0]  FD_LAST_IDX   = 3'd7;

  // Message kinds
  localparam logic [1:0] KIND_CONTROL = 2'd0;
  localparam logic [1:0] KIND_PEER    = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;

  // One received frame
  typedef struct packed {
    logic [10:0] can_id;
    logic        fd_format;
    logic [3:0]  dlc_code;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [63:0] word4;
    logic [63:0] word5;
    logic [63:0] word6;
    logic [63:0] word7;
  } in_req_t;

  // One emitted word
  typedef struct packed {
    logic [1:0]  msg_kind;
    logic [2:0]  word_index;
    logic [63:0] payload_word;
    logic        last;
  } out_req_t;

  // Frame classes
  typedef enum logic [2:0] {
    CLS_DROP,
    CLS_CONTROL,
    CLS_PEER,
    CLS_FD,
    CLS_FRAG_START,
    CLS_FRAG_ABORT,
    CLS_FRAG_STORE,
    CLS_FRAG_LAST
  } frame_class_t;

  // Decode result handed from the classifier to the sequencer
  typedef struct packed {
    frame_class_t cls;
    logic [2:0]   frag;
  } decision_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SINGLE,
    S_FD,
    S_PKT
  } state_t;

endpackage

>>> src/cfcr_store.sv
// ----------------------------------------------------------------------------
// cfcr_store
// Reassembly buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cfcr_store #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [63:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [63:0]       rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  // Write the fragment word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/cfcr_classify.sv
// ----------------------------------------------------------------------------
// cfcr_classify
// Sorts a held frame into control, peer control, FD data, fragment or drop.
// ----------------------------------------------------------------------------
module cfcr_classify import cfcr_pkg::*; #(
  parameter int PACKET_WORDS = 8
) (
  input  in_req_t     frame,
  input  logic [3:0]  peer_node_limit,
  input  logic        active,
  input  logic [2:0]  expected,
  output decision_t   dec
);

  localparam logic [3:0] PW4       = 4'(PACKET_WORDS);
  localparam logic [2:0] LAST_FRAG = 3'(PACKET_WORDS - 1);

  logic       classic;
  logic       dlc8;
  logic       is_control;
  logic       is_peer_range;
  logic       peer_match;
  logic       is_fd;
  logic       is_frag;
  logic [2:0] frag;

  // Match identifier, format and length
  always_comb begin
    classic       = !frame.fd_format;
    dlc8          = (frame.dlc_code == DLC_8_BYTES);
    frag          = frame.can_id[2:0];
    is_control    = classic && dlc8 && (frame.can_id == ID_CONTROL);
    is_peer_range = classic && dlc8 && (frame.can_id[10:4] == ID_PEER_HI)
                    && (frame.can_id[3:0] != 4'd0)
                    && (frame.can_id[3:0] <= peer_node_limit);
    peer_match    = (frame.word0[23:16] == {4'd0, frame.can_id[3:0]});
    is_fd         = frame.fd_format && (frame.can_id == ID_DATA_FIRST)
                    && (frame.dlc_code == DLC_64_BYTES);
    is_frag       = classic && dlc8 && (frame.can_id[10:3] == ID_FRAG_HI);
  end

  // Pick the class; fragments check order against the packet state
  always_comb begin
    dec.frag = frag;
    dec.cls  = CLS_DROP;
    if (is_control) begin
      dec.cls = CLS_CONTROL;
    end else if (is_peer_range) begin
      dec.cls = peer_match ? CLS_PEER : CLS_DROP;
    end else if (is_fd) begin
      dec.cls = CLS_FD;
    end else if (is_frag) begin
      if (frag == 3'd0) begin
        dec.cls = CLS_FRAG_START;
      end else if (!active || (frag != expected) || ({1'b0, frag} >= PW4)) begin
        dec.cls = CLS_FRAG_ABORT;
      end else if (frag == LAST_FRAG) begin
        dec.cls = CLS_FRAG_LAST;
      end else begin
        dec.cls = CLS_FRAG_STORE;
      end
    end
  end

endmodule

>>> src/can_frame_classifier_reassembler_core.sv
// ----------------------------------------------------------------------------
// can_frame_classifier_reassembler_core
// Classifies received CAN frames and reassembles ordered classic fragments.
//
// A frame is taken when the block is idle, held in the frame register while
// it is classified, and then its words leave one per cycle while the output
// side does not stall, through a single output register: a control or
// peer-control frame gives one word, an FD data frame eight and the final
// classic fragment PACKET_WORDS. The sequencer works on one frame at a time;
// packet words come out of the reassembly buffer through its one read port,
// the next read issued as each word is loaded. A new frame is taken while the
// last word still waits at the output.
// The reassembly buffer has no reset; only its control flags do.
// ----------------------------------------------------------------------------
module can_frame_classifier_reassembler_core import cfcr_pkg::*; #(
  parameter int PACKET_WORDS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_req,
  output logic       out_valid,
  input  logic       out_stall,
  output out_req_t   out_req,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  localparam int         ADDR_W   = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
  localparam logic [2:0] LAST_IDX = 3'(PACKET_WORDS - 1);

  state_t      state_r, state_nxt;
  in_req_t     frame_r;
  logic [3:0]  peer_node_limit_r;
  logic        active_r, active_nxt;
  logic [2:0]  expected_r, expected_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r;
  out_req_t    out_r, out_nxt;
  logic        load_out;
  logic        slot_free;
  logic        accept;
  decision_t   dec;
  logic [63:0] fd_word;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [63:0]       mem_rdata;

  cfcr_classify #(.PACKET_WORDS(PACKET_WORDS)) u_classify (
    .frame           (frame_r),
    .peer_node_limit (peer_node_limit_r),
    .active          (active_r),
    .expected        (expected_r),
    .dec             (dec)
  );

  cfcr_store #(.DEPTH(PACKET_WORDS), .ADDR_W(ADDR_W)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (frame_r.word0),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;

  // Select the FD payload word for the current index
  always_comb begin
    case (cnt_r)
      3'd0: fd_word = frame_r.word0;
      3'd1: fd_word = frame_r.word1;
      3'd2: fd_word = frame_r.word2;
      3'd3: fd_word = frame_r.word3;
      3'd4: fd_word = frame_r.word4;
      3'd5: fd_word = frame_r.word5;
      3'd6: fd_word = frame_r.word6;
      3'd7: fd_word = frame_r.word7;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (dec.cls)
          CLS_CONTROL, CLS_PEER: state_nxt = S_SINGLE;
          CLS_FD:                state_nxt = S_FD;
          CLS_FRAG_LAST:         state_nxt = S_PKT;
          default:               state_nxt = S_IDLE;
        endcase
      end
      S_SINGLE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_FD: begin
        if (slot_free && (cnt_r == FD_LAST_IDX)) state_nxt = S_IDLE;
      end
      S_PKT: begin
        if (slot_free && (cnt_r == LAST_IDX)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: buffer access, flags, counter, output word
  always_comb begin
    in_stall     = (state_r != S_IDLE);
    mem_we       = 1'b0;
    mem_waddr    = dec.frag[ADDR_W-1:0];
    mem_re       = 1'b0;
    mem_raddr    = '0;
    active_nxt   = active_r;
    expected_nxt = expected_r;
    cnt_nxt      = cnt_r;
    load_out     = 1'b0;
    out_nxt      = out_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_DECIDE: begin
        cnt_nxt = 3'd0;
        unique case (dec.cls)
          CLS_FRAG_START: begin
            mem_we       = 1'b1;
            active_nxt   = 1'b1;
            expected_nxt = 3'd1;
          end
          CLS_FRAG_ABORT: begin
            active_nxt   = 1'b0;
            expected_nxt = 3'd0;
          end
          CLS_FRAG_STORE: begin
            mem_we       = 1'b1;
            expected_nxt = expected_r + 3'd1;
          end
          CLS_FRAG_LAST: begin
            // write lands above entry 0, so the first read does not overlap
            mem_we       = 1'b1;
            mem_re       = 1'b1;
            active_nxt   = 1'b0;
            expected_nxt = 3'd0;
          end
          default: begin
          end
        endcase
      end
      S_SINGLE: begin
        load_out             = slot_free;
        out_nxt.msg_kind     = (dec.cls == CLS_PEER) ? KIND_PEER : KIND_CONTROL;
        out_nxt.word_index   = 3'd0;
        out_nxt.payload_word = frame_r.word0;
        out_nxt.last         = 1'b1;
      end
      S_FD: begin
        load_out             = slot_free;
        out_nxt.msg_kind     = KIND_DATA;
        out_nxt.word_index   = cnt_r;
        out_nxt.payload_word = fd_word;
        out_nxt.last         = (cnt_r == FD_LAST_IDX);
        if (slot_free) cnt_nxt = cnt_r + 3'd1;
      end
      S_PKT: begin
        load_out             = slot_free;
        out_nxt.msg_kind     = KIND_DATA;
        out_nxt.word_index   = cnt_r;
        out_nxt.payload_word = mem_rdata;
        out_nxt.last         = (cnt_r == LAST_IDX);
        // prefetch the next entry as this one goes out
        if (slot_free && (cnt_r != LAST_IDX)) begin
          cnt_nxt   = cnt_r + 3'd1;
          mem_re    = 1'b1;
          mem_raddr = cnt_nxt[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      active_r          <= 1'b0;
      expected_r        <= 3'd0;
      out_valid_r       <= 1'b0;
      peer_node_limit_r <= PEER_LIMIT_RESET;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      expected_r <= expected_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        peer_node_limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (accept) begin
      frame_r <= in_req;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

>>> src/cfcr_chk.sv
// ----------------------------------------------------------------------------
// cfcr_chk
// Port-level checks on the classifier and reassembler, bound to the top level.
// ----------------------------------------------------------------------------
module cfcr_chk import cfcr_pkg::*; #(
  parameter int PACKET_WORDS = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_req_t   out_req
);

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled output request changed");

  // Stay busy the cycle after a frame is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("frame taken without classify cycle");

  // Single-word messages sit at index 0 and close their message
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_req.msg_kind != KIND_DATA) |->
      (out_req.word_index == 3'd0) && out_req.last)
    else $error("control word malformed");

  // Data messages end only on the final index of an FD frame or packet
  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_req.msg_kind == KIND_DATA) && out_req.last |->
      (out_req.word_index == FD_LAST_IDX) ||
      (out_req.word_index == 3'(PACKET_WORDS - 1)))
    else $error("data message ended early");

  // Only data messages span more than one word
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.last |-> out_req.msg_kind == KIND_DATA)
    else $error("multi-word message is not data");

endmodule

bind can_frame_classifier_reassembler_core cfcr_chk #(
  .PACKET_WORDS(PACKET_WORDS)
) u_cfcr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_req     (out_req)
);

>>> verif/cfcr_word_checker.sv
// ----------------------------------------------------------------------------
// cfcr_word_checker
// Watches the frame, word and register ports of the CAN frame classifier.
// Predicts the words that each accepted frame must produce and compares every
// accepted word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfcr_word_checker import cfcr_pkg::*; #(
  parameter int PACKET_WORDS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_req_t    in_req,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_req_t   out_req,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output int         mismatch_count,
  output int         words_pending,
  output int         words_checked
);

  // Shadow copy of the block's register and reassembly state
  logic [3:0]  node_limit;
  logic        packet_open;
  logic [2:0]  next_frag;
  logic [63:0] packet_store [8];

  out_req_t expected_words [$];
  out_req_t want;

  // Count and report a field mismatch
  function automatic void flag_field(input string name, input logic [63:0] exp_val,
                                     input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  function automatic void queue_word(input logic [1:0] kind, input int idx,
                                     input logic [63:0] word, input logic last);
    out_req_t w;
    w.msg_kind     = kind;
    w.word_index   = 3'(idx);
    w.payload_word = word;
    w.last         = last;
    expected_words.push_back(w);
  endfunction

  // Classify one frame, update the reassembly state and queue its words
  function automatic void predict_frame_words(input in_req_t f);
    frame_class_t cls;
    logic [2:0]   frag;
    logic [63:0]  fd_words [8];
    cls  = CLS_DROP;
    frag = f.can_id[2:0];
    fd_words = '{f.word0, f.word1, f.word2, f.word3, f.word4, f.word5, f.word6, f.word7};
    if (!f.fd_format && f.dlc_code == DLC_8_BYTES) begin
      if (f.can_id == ID_CONTROL) begin
        cls = CLS_CONTROL;
      end else if (f.can_id[10:4] == ID_PEER_HI && f.can_id[3:0] != 4'd0
                   && f.can_id[3:0] <= node_limit) begin
        // Peer control needs payload byte 2 to name the sending node
        if (f.word0[23:16] == {4'd0, f.can_id[3:0]})
          cls = CLS_PEER;
      end else if (f.can_id[10:3] == ID_FRAG_HI) begin
        if (frag == 3'd0)
          cls = CLS_FRAG_START;
        else if (!packet_open || frag != next_frag || int'(frag) >= PACKET_WORDS)
          cls = CLS_FRAG_ABORT;
        else if (int'(frag) == PACKET_WORDS - 1)
          cls = CLS_FRAG_LAST;
        else
          cls = CLS_FRAG_STORE;
      end
    end else if (f.fd_format && f.can_id == ID_DATA_FIRST && f.dlc_code == DLC_64_BYTES) begin
      cls = CLS_FD;
    end

    case (cls)
      CLS_CONTROL: begin
        queue_word(KIND_CONTROL, 0, f.word0, 1'b1);
      end
      CLS_PEER: begin
        queue_word(KIND_PEER, 0, f.word0, 1'b1);
      end
      CLS_FD: begin
        for (int k = 0; k < 8; k++)
          queue_word(KIND_DATA, k, fd_words[k], k == 7);
      end
      CLS_FRAG_START: begin
        // Restart any packet in progress
        packet_store[0] = f.word0;
        packet_open     = 1'b1;
        next_frag       = 3'd1;
      end
      CLS_FRAG_ABORT: begin
        packet_open = 1'b0;
        next_frag   = 3'd0;
      end
      CLS_FRAG_STORE: begin
        packet_store[frag] = f.word0;
        next_frag          = next_frag + 3'd1;
      end
      CLS_FRAG_LAST: begin
        packet_store[frag] = f.word0;
        for (int k = 0; k < PACKET_WORDS; k++)
          queue_word(KIND_DATA, k, packet_store[k], k == PACKET_WORDS - 1);
        packet_open = 1'b0;
        next_frag   = 3'd0;
      end
      default: begin
      end
    endcase
  endfunction

  // Compare words first: a frame taken at this edge cannot yet have output
  always @(posedge clk) begin
    if (!rst_n) begin
      node_limit     = PEER_LIMIT_RESET;
      packet_open    = 1'b0;
      next_frag      = 3'd0;
      mismatch_count = 0;
      words_checked  = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          $error("word with no prediction: kind %0d index %0d payload 0x%0h",
                 out_req.msg_kind, out_req.word_index, out_req.payload_word);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          flag_field("msg_kind", 64'(want.msg_kind), 64'(out_req.msg_kind));
          flag_field("word_index", 64'(want.word_index), 64'(out_req.word_index));
          flag_field("payload_word", want.payload_word, out_req.payload_word);
          flag_field("last", 64'(want.last), 64'(out_req.last));
        end
      end
      if (in_valid && !in_stall)
        predict_frame_words(in_req);
      if (cfg_wr_en)
        node_limit = cfg_wr_data;
    end
    words_pending = expected_words.size();
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives received CAN frames into the frame classifier and reassembler:
// directed corner frames, then random traffic in which ordered fragment
// runs are the largest share, with broken runs, control, peer and FD frames
// and noise mixed in, over several peer node limits. Both channels idle at
// random; a checker predicts and compares the emitted words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import cfcr_pkg::*; ();

  localparam int PKT_WORDS    = 8;
  localparam int DRAIN_CYCLES = PKT_WORDS + 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_FRAMES = 25;
  localparam logic [10:0] PEER_ID_BASE = {ID_PEER_HI, 4'h0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_req_t   out_req;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;

  int          mismatch_count;
  int          words_pending;
  int          words_checked;
  int          frames_sent = 0;
  int          directed_frames = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  logic [2:0]  frag_cursor = 3'd0;

  can_frame_classifier_reassembler_core #(.PACKET_WORDS(PKT_WORDS)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_req     (out_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cfcr_word_checker #(.PACKET_WORDS(PKT_WORDS)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_req        (out_req),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending),
    .words_checked  (words_checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               words_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the word channel at random outside the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 32);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_req_t build_frame(input logic [10:0] id, input logic fd,
                                          input logic [3:0] dlc, input logic [63:0] w0);
    in_req_t f;
    f.can_id    = id;
    f.fd_format = fd;
    f.dlc_code  = dlc;
    f.word0     = w0;
    f.word1     = rand64();
    f.word2     = rand64();
    f.word3     = rand64();
    f.word4     = rand64();
    f.word5     = rand64();
    f.word6     = rand64();
    f.word7     = rand64();
    return f;
  endfunction

  // Peer frame from node 0..15; byte 2 names the node or holds another value
  function automatic in_req_t peer_frame(input logic [3:0] node, input bit named);
    in_req_t f;
    f = build_frame(PEER_ID_BASE + 11'(node), 1'b0, DLC_8_BYTES, rand64());
    if (named)
      f.word0[23:16] = {4'd0, node};
    else if (f.word0[23:16] == {4'd0, node})
      f.word0[23:16] = ~f.word0[23:16];
    return f;
  endfunction

  // Ordered fragment runs as the largest share, with occasional breaks, other kinds and noise
  function automatic in_req_t random_frame();
    int      pick;
    in_req_t f;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if ($urandom_range(99) < 8)
        frag_cursor = 3'($urandom_range(7));
      f = build_frame(ID_DATA_FIRST + 11'(frag_cursor), 1'b0, DLC_8_BYTES, rand64());
      frag_cursor = frag_cursor + 3'd1;
    end else if (pick < 50) begin
      f = build_frame(ID_CONTROL, 1'b0, DLC_8_BYTES, rand64());
    end else if (pick < 65) begin
      f = peer_frame(4'($urandom_range(15)), $urandom_range(3) != 0);
    end else if (pick < 75) begin
      f = build_frame(ID_DATA_FIRST, 1'b1, DLC_64_BYTES, rand64());
    end else if (pick < 87) begin
      // Near misses: a known id, mostly with a random format and length
      case ($urandom_range(2))
        0: f = build_frame(ID_CONTROL, 1'($urandom), 4'($urandom), rand64());
        1: f = build_frame(ID_DATA_FIRST + 11'($urandom_range(7)), 1'($urandom),
                           4'($urandom), rand64());
        default: f = peer_frame(4'($urandom_range(15)), 1'b1);
      endcase
      if (pick < 81) begin
        f.fd_format = 1'($urandom);
        f.dlc_code  = 4'($urandom);
      end
    end else begin
      f = build_frame(11'($urandom), 1'($urandom), 4'($urandom), rand64());
    end
    return f;
  endfunction

  // Present one request after a random gap and hold it until taken
  task automatic send_frame(input in_req_t f);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 32)
      gap++;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= f;
    do @(posedge clk); while (in_stall);
    frames_sent++;
  endtask

  // Hold off new requests until every predicted word has left the block
  task automatic drain_words();
    @(negedge clk) in_valid <= 1'b0;
    while (words_pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_limit(input logic [3:0] limit);
    drain_words();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_req_t    f;
    logic [3:0] limits [5];
    limits = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(2, 14)), 4'd8};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Control frames and their near misses
    f = build_frame(ID_CONTROL, 1'b0, DLC_8_BYTES, '1);
    send_frame(f);
    send_frame(build_frame(ID_CONTROL, 1'b0, DLC_8_BYTES, '0));
    send_frame(build_frame(ID_CONTROL, 1'b1, DLC_8_BYTES, rand64()));
    send_frame(build_frame(ID_CONTROL, 1'b0, DLC_64_BYTES, rand64()));

    // Peer control at the reset node limit: lowest, highest, above, wrong byte, base
    send_frame(peer_frame(4'd1, 1'b1));
    send_frame(peer_frame(4'd8, 1'b1));
    send_frame(peer_frame(4'd9, 1'b1));
    send_frame(peer_frame(4'd5, 1'b0));
    send_frame(peer_frame(4'd0, 1'b1));

    // FD data: all ones, random, wrong length, top id
    f = '1;
    f.can_id    = ID_DATA_FIRST;
    f.fd_format = 1'b1;
    f.dlc_code  = DLC_64_BYTES;
    send_frame(f);
    send_frame(build_frame(ID_DATA_FIRST, 1'b1, DLC_64_BYTES, rand64()));
    send_frame(build_frame(ID_DATA_FIRST, 1'b1, DLC_8_BYTES, rand64()));
    send_frame(build_frame(11'h7FF, 1'b1, DLC_64_BYTES, '1));

    // Restarted packet, then the full ordered run
    send_frame(build_frame(ID_DATA_FIRST, 1'b0, DLC_8_BYTES, rand64()));
    send_frame(build_frame(ID_DATA_FIRST + 11'd1, 1'b0, DLC_8_BYTES, rand64()));
    for (int k = 0; k < PKT_WORDS; k++)
      send_frame(build_frame(ID_DATA_FIRST + 11'(k), 1'b0, DLC_8_BYTES, rand64()));

    // Out-of-order fragment, then a fragment with no packet open
    send_frame(build_frame(ID_DATA_FIRST, 1'b0, DLC_8_BYTES, rand64()));
    send_frame(build_frame(ID_DATA_FIRST + 11'd2, 1'b0, DLC_8_BYTES, rand64()));
    send_frame(build_frame(ID_DATA_FIRST + 11'd5, 1'b0, DLC_8_BYTES, rand64()));
    directed_frames = frames_sent;

    // Random traffic under each node limit; the third phase adds no random gaps or stalls
    for (int p = 0; p < 5; p++) begin
      write_node_limit(limits[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if ($urandom_range(99) < 4)
          drain_words();
        send_frame(random_frame());
      end
    end
    steady = 1'b0;

    drain_words();
    $display("Sent %0d frames (%0d directed) under peer node limits 8, 15, 0, 1, %0d, 8",
             frames_sent, directed_frames, limits[3]);
    $display("Compared %0d emitted words in %0d cycles", words_checked, cycle_count);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
src/cfcr_pkg.sv
src/cfcr_store.sv
src/cfcr_classify.sv
src/can_frame_classifier_reassembler_core.sv
src/cfcr_chk.sv
verif/cfcr_word_checker.sv
verif/tb.sv
